[rtl/core/heightmap_bilinear_sample_unit_macros.svh]
// Assertion macros shared by the heightmap sampler RTL.
`ifndef HEIGHTMAP_BILINEAR_SAMPLE_UNIT_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define HBS_ASSERT_NOW(lbl, clk_i, rstn_i, pre, post) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (pre) |-> (post)) \
		else $error("assertion failed");
`define HBS_ASSERT_NEXT(lbl, clk_i, rstn_i, pre, post) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define HBS_ASSERT_NOW(lbl, clk_i, rstn_i, pre, post)
`define HBS_ASSERT_NEXT(lbl, clk_i, rstn_i, pre, post)
`endif
`endif

[rtl/core/hbs_pkg.sv]
// Package with types, constants and the lerp function of the heightmap sampler.
`default_nettype none
package hbs_pkg;
	localparam int MAX_SIDE  = 256;
	localparam int FRAC_BITS = 16;
	localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int DIM_W     = 9;
	localparam int IDX_W     = 2 * DIM_W + 1;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_GRID_WIDTH  = 3'd0,
		REG_GRID_LENGTH = 3'd1,
		REG_INV_CELL_X  = 3'd2,
		REG_INV_CELL_Z  = 3'd3,
		REG_HALF_X      = 3'd4,
		REG_HALF_Z      = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAP, ST_BND, ST_ROW, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
		ST_WAIT, ST_LERP0, ST_LERP1, ST_DONE
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       map;
		logic       bnd;
		logic       row;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       cap_en;
		logic [1:0] cap_sel;
		logic       lerp0;
		logic       lerp1;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	// a + floor((b - a) * t / 2^FRAC_BITS)
	function automatic logic [31:0] lerp(input logic [31:0] a, input logic [31:0] b,
			input logic [FRAC_BITS-1:0] t);
		logic signed [32:0] d;
		logic signed [FRAC_BITS:0] ts;
		logic signed [33+FRAC_BITS:0] p;
		logic signed [33+FRAC_BITS:0] sh;
		d  = $signed({b[31], b}) - $signed({a[31], a});
		ts = $signed({1'b0, t});
		p  = d * ts;
		sh = p >>> FRAC_BITS;
		return a + sh[31:0];
	endfunction
endpackage
`default_nettype wire

[rtl/core/hbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/core/hbs_ctrl.sv]
// Controller state machine sequencing one query through the datapath.
`default_nettype none
module hbs_ctrl import hbs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic [1:0] mode,
	input  wire status_t status,
	output logic         in_stall,
	output cmd_t         cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (mode == MODE_QUERY) state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				state_d = ST_BND;
			end
			ST_BND: begin
				cmd.bnd = 1'b1;
				state_d = ST_ROW;
			end
			ST_ROW: begin
				cmd.row = 1'b1;
				state_d = ST_RD0;
			end
			ST_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = 2'd0;
				state_d    = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = 2'd1;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = 2'd0;
				state_d     = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = 2'd2;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = 2'd1;
				state_d     = ST_RD3;
			end
			ST_RD3: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = 2'd3;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = 2'd2;
				state_d     = ST_WAIT;
			end
			ST_WAIT: begin
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = 2'd3;
				state_d     = ST_LERP0;
			end
			ST_LERP0: begin
				cmd.lerp0 = 1'b1;
				state_d   = ST_LERP1;
			end
			ST_LERP1: begin
				cmd.lerp1 = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/hbs_datapath.sv]
// Datapath: configuration, height store, axis mapping, addressing and blending.
`default_nettype none
module hbs_datapath import hbs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          status,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] height_in,
	input  wire logic [31:0] world_x,
	input  wire logic [31:0] world_z,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        out_stall,
	output logic             out_valid,
	output logic [31:0]      height_out,
	output logic             inside_res,
	output logic             store_overflow
);
	logic [DIM_W-1:0] grid_width_q, grid_length_q;
	logic [31:0] inv_x_q, inv_z_q, half_x_q, half_z_q;
	logic [CNT_W-1:0] count_q;
	logic ovf_q;
	logic [31:0] wx_q, wz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= '0;
			grid_length_q <= '0;
			inv_x_q       <= 32'd65536;
			inv_z_q       <= 32'd65536;
			half_x_q      <= '0;
			half_z_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[DIM_W-1:0];
				REG_GRID_LENGTH: grid_length_q <= cfg_data[DIM_W-1:0];
				REG_INV_CELL_X:  inv_x_q       <= cfg_data;
				REG_INV_CELL_Z:  inv_z_q       <= cfg_data;
				REG_HALF_X:      half_x_q      <= cfg_data;
				REG_HALF_Z:      half_z_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	logic full, we;
	assign full = (count_q == CNT_W'(DEPTH));
	assign we   = cmd.accept && (mode == MODE_LOAD) && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.accept) begin
			case (mode)
				MODE_LOAD: begin
					if (full) ovf_q <= 1'b1;
					else count_q <= count_q + 1'b1;
				end
				MODE_CLEAR: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			wx_q <= world_x;
			wz_q <= world_z;
		end
	end

	// Stage 1: offset and scale each axis.
	logic [32:0] sum_x, sum_z, mag_x, mag_z;
	logic [63:0] prod_x, prod_z, prod_x_s1, prod_z_s1;
	logic neg_x_s1, neg_z_s1;
	assign sum_x  = {wx_q[31], wx_q} + {half_x_q[31], half_x_q};
	assign sum_z  = {wz_q[31], wz_q} + {half_z_q[31], half_z_q};
	assign mag_x  = sum_x[32] ? (33'd0 - sum_x) : sum_x;
	assign mag_z  = sum_z[32] ? (33'd0 - sum_z) : sum_z;
	assign prod_x = (mag_x[31:0] * inv_x_q) + (mag_x[32] ? {inv_x_q, 32'd0} : 64'd0);
	assign prod_z = (mag_z[31:0] * inv_z_q) + (mag_z[32] ? {inv_z_q, 32'd0} : 64'd0);

	always_ff @(posedge clk) begin
		if (cmd.map) begin
			prod_x_s1 <= prod_x;
			prod_z_s1 <= prod_z;
			neg_x_s1  <= sum_x[32];
			neg_z_s1  <= sum_z[32];
		end
	end

	// Stage 2: bounds test and cell coordinates.
	logic [63:0] loc_x, loc_z, bnd_x, bnd_z;
	logic [31:0] wm1, lm1;
	logic ins_x, ins_z, calc;
	logic [DIM_W:0] x0p1, z0p1;
	logic [DIM_W-1:0] x0_s2, z0_s2, x1_s2, z1_s2;
	logic [FRAC_BITS-1:0] tx_s2, tz_s2;
	logic inside_s2, calc_s2;
	assign loc_x = neg_x_s1 ? 64'd0 : (prod_x_s1 >> FRAC_BITS);
	assign loc_z = neg_z_s1 ? 64'd0 : (prod_z_s1 >> FRAC_BITS);
	assign wm1   = {{(32-DIM_W){1'b0}}, grid_width_q} - 32'd1;
	assign lm1   = {{(32-DIM_W){1'b0}}, grid_length_q} - 32'd1;
	assign bnd_x = {32'd0, wm1} << FRAC_BITS;
	assign bnd_z = {32'd0, lm1} << FRAC_BITS;
	assign ins_x = !(neg_x_s1 && prod_x_s1 != 64'd0) && (loc_x <= bnd_x);
	assign ins_z = !(neg_z_s1 && prod_z_s1 != 64'd0) && (loc_z <= bnd_z);
	assign calc  = ins_x && ins_z && (count_q != '0) &&
		(grid_width_q >= DIM_W'(2)) && (grid_length_q >= DIM_W'(2));
	assign x0p1  = {1'b0, loc_x[FRAC_BITS+DIM_W-1:FRAC_BITS]} + 1'b1;
	assign z0p1  = {1'b0, loc_z[FRAC_BITS+DIM_W-1:FRAC_BITS]} + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.bnd) begin
			inside_s2 <= ins_x && ins_z;
			calc_s2   <= calc;
			x0_s2     <= loc_x[FRAC_BITS+DIM_W-1:FRAC_BITS];
			z0_s2     <= loc_z[FRAC_BITS+DIM_W-1:FRAC_BITS];
			tx_s2     <= loc_x[FRAC_BITS-1:0];
			tz_s2     <= loc_z[FRAC_BITS-1:0];
			x1_s2     <= (x0p1 < {1'b0, grid_width_q}) ? x0p1[DIM_W-1:0] : wm1[DIM_W-1:0];
			z1_s2     <= (z0p1 < {1'b0, grid_length_q}) ? z0p1[DIM_W-1:0] : lm1[DIM_W-1:0];
		end
	end

	// Stage 3: four sample indices and their loaded flags.
	logic [2*DIM_W-1:0] row0, row1;
	logic [IDX_W-1:0] idx [4];
	logic [IDX_W-1:0] idx_s3 [4];
	logic [3:0] ok_s3;
	assign row0   = z0_s2 * grid_width_q;
	assign row1   = z1_s2 * grid_width_q;
	assign idx[0] = {1'b0, row0} + IDX_W'(x0_s2);
	assign idx[1] = {1'b0, row0} + IDX_W'(x1_s2);
	assign idx[2] = {1'b0, row1} + IDX_W'(x0_s2);
	assign idx[3] = {1'b0, row1} + IDX_W'(x1_s2);

	always_ff @(posedge clk) begin
		if (cmd.row) begin
			for (int i = 0; i < 4; i++) begin
				idx_s3[i] <= idx[i];
				ok_s3[i]  <= (idx[i] < IDX_W'(count_q));
			end
		end
	end

	// Height store.
	logic [31:0] rdata;
	hbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (height_in),
		.re    (cmd.rd_en),
		.raddr (idx_s3[cmd.rd_sel][ADDR_W-1:0]),
		.rdata (rdata)
	);

	logic [31:0] smp_q [4];
	logic [31:0] h0_q, h1_q, hres_q;
	always_ff @(posedge clk) begin
		if (cmd.cap_en) smp_q[cmd.cap_sel] <= ok_s3[cmd.cap_sel] ? rdata : 32'd0;
		if (cmd.lerp0) begin
			h0_q <= lerp(smp_q[0], smp_q[1], tx_s2);
			h1_q <= lerp(smp_q[2], smp_q[3], tx_s2);
		end
		if (cmd.lerp1) hres_q <= lerp(h0_q, h1_q, tz_s2);
	end

	// Output register.
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			height_out     <= calc_s2 ? hres_q : 32'd0;
			inside_res     <= inside_s2;
			store_overflow <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || !out_stall;
endmodule
`default_nettype wire

[rtl/core/heightmap_bilinear_sample_unit.sv]
// Top level of the bilinear heightmap sampler.
// Load and clear transfers give no result. A query transfer places its result in the
// output register after these steps, in order: axis scaling, the bounds test, row
// addressing, four reads of the single read port of the height store, a wait for the
// last read data, two blending steps and the load of the output register, which waits
// while the output side stalls with a result still held. The next input transfer is
// taken the cycle after the result is placed in the output register, so a query is
// through before the next transfer is taken. The single read port of the store is why
// the four reads are separate steps. Read data is only used at indices below the load
// count, so the store needs no clearing after reset.
`default_nettype none
`include "heightmap_bilinear_sample_unit_macros.svh"
module heightmap_bilinear_sample_unit import hbs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] height_in,
	input  wire logic [31:0] world_x,
	input  wire logic [31:0] world_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      height_out,
	output logic             inside_res,
	output logic             store_overflow,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	cmd_t    cmd;
	status_t status;

	// Configuration writes are always taken; the user must send them only while idle.
	assign cfg_ready = 1'b1;

	hbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	hbs_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.mode           (mode),
		.height_in      (height_in),
		.world_x        (world_x),
		.world_z        (world_z),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.height_out     (height_out),
		.inside_res     (inside_res),
		.store_overflow (store_overflow)
	);

	// A point outside the grid always reports a zero height.
	`HBS_ASSERT_NOW(a_outside_zero, clk, arst_n, out_valid && !inside_res, height_out == 32'd0)
	// After a query transfer the block is busy.
	`HBS_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && !in_stall && mode == MODE_QUERY, in_stall)
	// A waiting result is never overwritten.
	`HBS_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.out_load, !(out_valid && out_stall))
endmodule
`default_nettype wire

[test/tb_heightmap_bilinear_sample_unit.sv]
// Self-checking testbench of the bilinear heightmap sampler unit.
`timescale 1ns / 1ps
`default_nettype none

module tb_heightmap_bilinear_sample_unit;
	import hbs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 20;
	localparam int N_DIRECTED  = 21;

	typedef struct packed {
		logic [31:0] height;
		logic        in_grid;
		logic        ovf;
	} sample_res_t;

	// One row of the directed table. Where given is set, the expected result is
	// typed into the row; otherwise the predictor supplies it.
	typedef struct packed {
		mode_t       m;
		logic [31:0] h;
		logic [31:0] x;
		logic [31:0] z;
		logic        given;
		logic [31:0] eh;
		logic        ei;
		logic        eo;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [31:0] height_in;
	logic [31:0] world_x;
	logic [31:0] world_z;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] height_out;
	logic        inside_res;
	logic        store_overflow;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// Predictor state: its own copy of the height store and of every register.
	logic [31:0]        mirror_store [0:DEPTH-1];
	logic [CNT_W-1:0]   mirror_count;
	logic               mirror_ovf;
	logic [8:0]         p_width;
	logic [8:0]         p_length;
	logic [31:0]        p_inv_x;
	logic [31:0]        p_inv_z;
	logic signed [31:0] p_half_x;
	logic signed [31:0] p_half_z;

	sample_res_t pending_heights[$];
	int          mismatches;
	int          cycles;
	logic        calm;

	heightmap_bilinear_sample_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .height_in(height_in), .world_x(world_x), .world_z(world_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.height_out(height_out), .inside_res(inside_res), .store_overflow(store_overflow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Maps one world coordinate into grid space. The sum is exact in 33 bits;
	// a negative sum is outside unless the scaled product is zero. The upper
	// bound uses dim - 1 as a 32-bit value, so a zero dimension wraps to a
	// bound that nothing reaches.
	function automatic logic map_to_grid(input logic signed [31:0] w,
			input logic signed [31:0] half, input logic [31:0] inv,
			input logic [8:0] dim, output logic [63:0] loc);
		longint      s;
		logic [63:0] mag;
		logic [63:0] prod;
		logic [31:0] dm1;
		logic [63:0] bnd;
		s    = longint'(w) + longint'(half);
		mag  = (s < 0) ? 64'(-s) : 64'(s);
		prod = mag * {32'd0, inv};
		dm1  = {23'd0, dim} - 32'd1;
		bnd  = {32'd0, dm1} << FRAC_BITS;
		loc  = '0;
		if (s < 0 && prod != 0)
			return 1'b0;
		if (s >= 0)
			loc = prod >> FRAC_BITS;
		return loc <= bnd;
	endfunction

	// a + floor((b - a) * t / 2^16); the arithmetic shift of a signed value
	// rounds towards minus infinity.
	function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
			input logic [15:0] t);
		longint d;
		longint p;
		d = longint'($signed(b)) - longint'($signed(a));
		p = d * longint'({48'd0, t});
		return a + 32'(p >>> FRAC_BITS);
	endfunction

	// Neighbours at or beyond the load count read as zero.
	function automatic logic [31:0] grid_sample(input logic [31:0] x, input logic [31:0] z);
		longint idx;
		idx = longint'(z) * longint'(p_width) + longint'(x);
		if (idx < longint'(mirror_count) && idx < DEPTH)
			return mirror_store[idx];
		return '0;
	endfunction

	// Applies one accepted transfer to the predictor and returns whether it gives a result.
	function automatic logic predict_sample(input mode_t m, input logic [31:0] h,
			input logic [31:0] x, input logic [31:0] z, output sample_res_t r);
		logic [63:0] lx;
		logic [63:0] lz;
		logic        in_x;
		logic        in_z;
		logic [31:0] x0, z0, x1, z1;
		logic [31:0] h0, h1;
		r = '0;
		case (m)
			MODE_LOAD: begin
				if (mirror_count < DEPTH) begin
					mirror_store[mirror_count[ADDR_W-1:0]] = h;
					mirror_count = mirror_count + 1'b1;
				end else begin
					mirror_ovf = 1'b1;
				end
				return 1'b0;
			end
			MODE_CLEAR: begin
				mirror_count = '0;
				mirror_ovf   = 1'b0;
				return 1'b0;
			end
			MODE_QUERY: begin
				in_x = map_to_grid(x, p_half_x, p_inv_x, p_width, lx);
				in_z = map_to_grid(z, p_half_z, p_inv_z, p_length, lz);
				r.in_grid = in_x && in_z;
				r.ovf     = mirror_ovf;
				if (r.in_grid && mirror_count != 0 && p_width >= 2 && p_length >= 2) begin
					x0 = 32'(lx >> FRAC_BITS);
					z0 = 32'(lz >> FRAC_BITS);
					x1 = (x0 + 1 < p_width) ? x0 + 1 : p_width - 1;
					z1 = (z0 + 1 < p_length) ? z0 + 1 : p_length - 1;
					h0 = blend(grid_sample(x0, z0), grid_sample(x1, z0), lx[15:0]);
					h1 = blend(grid_sample(x0, z1), grid_sample(x1, z1), lx[15:0]);
					r.height = blend(h0, h1, lz[15:0]);
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Output side: stalls about a quarter of the time except in calm stretches,
	// and checks every result transfer against the oldest expectation.
	always @(posedge clk) begin
		sample_res_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_heightmap_bilinear_sample_unit: done, errors");
			$finish;
		end
		out_stall <= !calm && ($urandom_range(99) < 25);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_heights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: height %h inside %b ovf %b",
						height_out, inside_res, store_overflow);
			end else begin
				e = pending_heights.pop_front();
				if (height_out !== e.height || inside_res !== e.in_grid ||
						store_overflow !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected h %h in %b ovf %b, got h %h in %b ovf %b",
							e.height, e.in_grid, e.ovf, height_out, inside_res,
							store_overflow);
				end
			end
		end
	end

	// Appends one expected result to the back of the queue.
	task automatic queue_result(input sample_res_t r);
		pending_heights = {pending_heights, r};
	endtask

	// Writes one register. Called just after a rising edge, returns just after one.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GRID_WIDTH:  p_width  = v[8:0];
			REG_GRID_LENGTH: p_length = v[8:0];
			REG_INV_CELL_X:  p_inv_x  = v;
			REG_INV_CELL_Z:  p_inv_z  = v;
			REG_HALF_X:      p_half_x = v;
			REG_HALF_Z:      p_half_z = v;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [8:0] w, input logic [8:0] l, input logic [31:0] ix,
			input logic [31:0] iz, input logic [31:0] hx, input logic [31:0] hz);
		write_reg(REG_GRID_WIDTH, {23'd0, w});
		write_reg(REG_GRID_LENGTH, {23'd0, l});
		write_reg(REG_INV_CELL_X, ix);
		write_reg(REG_INV_CELL_Z, iz);
		write_reg(REG_HALF_X, hx);
		write_reg(REG_HALF_Z, hz);
	endtask

	// Sends one input transfer and returns at the edge where it was taken.
	// A random gap lowers valid first; otherwise valid simply stays high.
	task automatic send_item(input mode_t m, input logic [31:0] h, input logic [31:0] x,
			input logic [31:0] z, output sample_res_t r, output logic has_res);
		int gap;
		gap = (!calm && $urandom_range(99) < 25) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		height_in <= h;
		world_x   <= x;
		world_z   <= z;
		do @(posedge clk); while (in_stall);
		has_res = predict_sample(m, h, x, z, r);
	endtask

	task automatic send_checked(input mode_t m, input logic [31:0] h, input logic [31:0] x,
			input logic [31:0] z);
		sample_res_t r;
		logic        has_res;
		send_item(m, h, x, z, r, has_res);
		if (has_res)
			queue_result(r);
	endtask

	// Lets every expected result arrive and the block fall idle.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_heights.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// World coordinate that lands near a chosen grid position, so that most
	// queries fall inside the grid. A fifth of them, and all when inv is zero, are fully random.
	function automatic logic [31:0] world_near(input logic [8:0] dim, input logic [31:0] inv,
			input logic signed [31:0] half);
		longint span;
		longint loc;
		longint w;
		if (inv == 0 || $urandom_range(99) < 20)
			return $urandom;
		span = (dim < 2) ? 3 : dim - 1;
		loc  = longint'($urandom_range(0, 32'(span * 65536 + 65536)));
		w    = (loc << FRAC_BITS) / longint'({32'd0, inv}) - longint'(half);
		if (w > 64'sh7FFFFFFF)
			w = 64'sh7FFFFFFF;
		if (w < -64'sh80000000)
			w = -64'sh80000000;
		return 32'(w);
	endfunction

	function automatic logic [31:0] rand_height;
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_inv;
		case ($urandom_range(4))
			0: return 32'd65536;
			1: return 32'd32768;
			2: return 32'd131072;
			3: return 32'(int'($urandom_range(8192, 300000)));
			default: return $urandom;
		endcase
	endfunction

	// Directed table: extremes of the fields, every mode, the empty store, an
	// unloaded neighbour, the far-edge clamp, points outside and a clear.
	// It runs on a two by two grid of unit cells with no offset.
	dir_row_t dir_table [N_DIRECTED] = '{
		'{MODE_QUERY, 32'h0, 32'h0,        32'h0,        1'b1, 32'h0,        1'b1, 1'b0},
		'{MODE_QUERY, 32'h0, 32'hFFFFFFFF, 32'h0,        1'b1, 32'h0,        1'b0, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h7FFFFFFF, 32'h0,        1'b1, 32'h0,        1'b0, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h0,        32'h80000000, 1'b1, 32'h0,        1'b0, 1'b0},
		'{MODE_NONE,  32'h0, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_LOAD,  32'h7FFFFFFF, 32'h0, 32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_LOAD,  32'h80000000, 32'h0, 32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h8000,     32'h8000,     1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_LOAD,  32'h0, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_LOAD,  32'h1, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h0,        32'h0,        1'b1, 32'h7FFFFFFF, 1'b1, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h10000,    32'h0,        1'b1, 32'h80000000, 1'b1, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h8000,     32'h8000,     1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_QUERY, 32'h0, 32'hFFFF,     32'hFFFF,     1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h10000,    32'h10000,    1'b1, 32'h1,        1'b1, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h10001,    32'h0,        1'b1, 32'h0,        1'b0, 1'b0},
		'{MODE_LOAD,  32'h12345678, 32'h0, 32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h4000,     32'hC000,     1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_CLEAR, 32'h0, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0, 1'b0},
		'{MODE_QUERY, 32'h0, 32'h0,        32'h0,        1'b1, 32'h0,        1'b1, 1'b0},
		'{MODE_NONE,  32'h0, 32'h0,        32'h0,        1'b0, 32'h0,        1'b0, 1'b0}
	};

	initial begin
		sample_res_t r;
		logic        has_res;
		logic [8:0]  w, l;
		logic [31:0] ix, iz, hx, hz;
		int          n_load;
		int          pick;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = MODE_NONE;
		height_in = '0;
		world_x   = '0;
		world_z   = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data  = '0;
		cycles     = 0;
		mismatches = 0;
		calm       = 1'b0;
		mirror_count = '0;
		mirror_ovf   = 1'b0;
		p_width  = '0;
		p_length = '0;
		p_inv_x  = 32'd65536;
		p_inv_z  = 32'd65536;
		p_half_x = '0;
		p_half_z = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The typed expectation replaces the predicted one,
		// but the predictor still sees every transfer to keep its state.
		write_all(9'd2, 9'd2, 32'd65536, 32'd65536, 32'd0, 32'd0);
		foreach (dir_table[i]) begin
			send_item(dir_table[i].m, dir_table[i].h, dir_table[i].x, dir_table[i].z,
				r, has_res);
			if (has_res) begin
				if (dir_table[i].given)
					r = '{dir_table[i].eh, dir_table[i].ei, dir_table[i].eo};
				queue_result(r);
			end
		end
		drain();

		// Random phases, each under its own setting. The first few take the
		// extremes of the registers; one phase runs with no idling at all.
		for (int ph = 0; ph < 14; ph++) begin
			case (ph)
				0: begin w = 9'd0; l = 9'd1; ix = 32'd65536; iz = 32'd65536;
					hx = 32'd0; hz = 32'd0; end
				1: begin w = 9'd256; l = 9'd2; ix = 32'd1; iz = 32'hFFFFFFFF;
					hx = 32'h7FFFFFFF; hz = 32'h80000000; end
				2: begin w = 9'd3; l = 9'd256; ix = 32'd0; iz = 32'd65536;
					hx = 32'h80000000; hz = 32'h7FFFFFFF; end
				3: begin w = 9'd1; l = 9'd0; ix = 32'hFFFFFFFF; iz = 32'd0;
					hx = 32'd0; hz = 32'd0; end
				default: begin
					w  = 9'($urandom_range(2, 12));
					l  = 9'($urandom_range(2, 12));
					ix = rand_inv();
					iz = rand_inv();
					hx = 32'(int'($urandom_range(0, 40 * 65536)) - 20 * 65536);
					hz = 32'(int'($urandom_range(0, 40 * 65536)) - 20 * 65536);
				end
			endcase
			write_all(w, l, ix, iz, hx, hz);
			calm = (ph == 6);
			send_checked(MODE_CLEAR, $urandom, $urandom, $urandom);
			n_load = (int'(w) * int'(l) > 64) ? 64 : int'(w) * int'(l);
			if ($urandom_range(3) == 0)
				n_load = $urandom_range(0, n_load);
			for (int k = 0; k < n_load; k++)
				send_checked(MODE_LOAD, rand_height(), $urandom, $urandom);
			for (int k = 0; k < 40; k++) begin
				pick = $urandom_range(99);
				if (pick < 6)
					send_checked(MODE_LOAD, rand_height(), $urandom, $urandom);
				else if (pick < 8)
					send_checked(MODE_CLEAR, $urandom, $urandom, $urandom);
				else if (pick < 10)
					send_checked(MODE_NONE, $urandom, $urandom, $urandom);
				else
					send_checked(MODE_QUERY, $urandom, world_near(w, ix, hx),
						world_near(l, iz, hz));
			end
			// The sender holds off here until every result has come back.
			drain();
		end
		calm = 1'b0;

		// Largest grid with a partly loaded store: the far corners use the
		// far-edge clamp and read unloaded neighbours, then a clear.
		write_all(9'd256, 9'd256, 32'd65536, 32'd65536, 32'd0, 32'd0);
		send_checked(MODE_CLEAR, '0, '0, '0);
		for (int k = 0; k < 150; k++)
			send_checked(MODE_LOAD, rand_height(), $urandom, $urandom);
		send_checked(MODE_QUERY, '0, 32'h00FF0000, 32'h00FF0000);
		send_checked(MODE_QUERY, '0, 32'h00FE8000, 32'h00FF0000);
		send_checked(MODE_QUERY, '0, 32'h0, 32'h0);
		send_checked(MODE_QUERY, '0, 32'h00008000, 32'h00000000);
		for (int k = 0; k < 60; k++)
			send_checked(MODE_QUERY, '0, world_near(9'd256, 32'd65536, 32'd0),
				world_near(9'd2, 32'd65536, 32'd0));
		send_checked(MODE_CLEAR, '0, '0, '0);
		send_checked(MODE_QUERY, '0, 32'h00010000, 32'h00010000);
		drain();

		if (mismatches == 0 && pending_heights.size() == 0) begin
			$display("tb_heightmap_bilinear_sample_unit: done, clean");
		end else begin
			$display("tb_heightmap_bilinear_sample_unit: done, errors");
		end
		$finish;
	end
endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/hbs_pkg.sv
rtl/core/hbs_ram.sv
rtl/core/hbs_ctrl.sv
rtl/core/hbs_datapath.sv
rtl/core/heightmap_bilinear_sample_unit.sv
test/tb_heightmap_bilinear_sample_unit.sv
